>>> rtl/ipcp_pkg.sv
package ipcp_pkg;

  // largest message body the parser walks
  localparam int unsigned MaxMessageBytesDef = 65535;

  // next payload type that closes the chain
  localparam logic [7:0] IsakmpNptypeNone = 8'h00;

  // generic payload header size in bytes
  localparam logic [15:0] HdrBytes = 16'd4;

  typedef enum logic [1:0] {
    KindPayload = 2'd0,
    KindDone    = 2'd1,
    KindShort   = 2'd2,
    KindBadLen  = 2'd3
  } rec_kind_e;

  typedef struct packed {
    rec_kind_e   kind;
    logic [7:0]  ptype;
    logic [7:0]  pnext;
    logic [15:0] offset;
    logic [15:0] length;
    logic        last;
  } result_t;

endpackage

>>> rtl/isakmp_payload_chain_parser.sv
// ISAKMP generic payload chain parser. Message body bytes come in one request per
// cycle while in_ready_o is high; first_byte_i marks the start of a message and
// carries its first payload type and total body length. Each 4-byte generic
// header (next type, reserved, 16-bit big-endian length) gives a payload record;
// the closing done, too-few-bytes or bad-length record follows in the next output
// slot when it is decided by the same header byte (run_last_o marks the final
// record of a byte). One byte is accepted every cycle while the queue has room:
// the byte sits in an input register, the chain state is updated by a single
// pass of compare and subtract logic, and its records enter a four-entry result
// queue. A byte is processed when the queue has room for two records, so a
// stalled output side fills the queue before input stops. A byte's records go
// from the input register to the queue. Bytes outside a message produce nothing.
module isakmp_payload_chain_parser #(
  parameter int unsigned MaxMessageBytes = ipcp_pkg::MaxMessageBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  byte_value_i,
  input  logic        first_byte_i,
  input  logic [7:0]  start_type_i,
  input  logic [15:0] message_length_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  record_kind_o,
  output logic [7:0]  payload_type_o,
  output logic [7:0]  payload_next_o,
  output logic [15:0] payload_offset_o,
  output logic [15:0] payload_length_o,
  output logic        run_last_o
);
  import ipcp_pkg::*;

  localparam logic [15:0] MaxLen = 16'(MaxMessageBytes);

  typedef enum logic [1:0] {
    PhIdle,
    PhHeader,
    PhBody
  } phase_e;

  // input register
  logic        s1_valid_q;
  logic [7:0]  s1_byte_q;
  logic        s1_first_q;
  logic [7:0]  s1_start_q;
  logic [15:0] s1_len_q;
  logic        s1_fire;

  // chain state
  phase_e      phase_q, phase_d;
  logic [1:0]  hdr_idx_q, hdr_idx_d;
  logic [7:0]  cur_type_q, cur_type_d;
  logic [7:0]  hdr_next_q, hdr_next_d;
  logic [7:0]  len_hi_q, len_hi_d;
  logic [15:0] remain_q, remain_d;
  logic [15:0] body_left_q, body_left_d;
  logic [15:0] byte_pos_q, byte_pos_d;

  // records raised by the current byte
  result_t     res0, res1;
  logic [1:0]  n_res;

  // result queue
  result_t     queue_q [4];
  logic [1:0]  wr_ptr_q, rd_ptr_q;
  logic [2:0]  count_q;
  logic        pop;

  assign s1_fire    = s1_valid_q && (count_q <= 3'd2);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign pop        = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_byte_q  <= byte_value_i;
      s1_first_q <= first_byte_i;
      s1_start_q <= start_type_i;
      s1_len_q   <= message_length_i;
    end
  end

  // one pass over the byte held in the input register
  always_comb begin
    logic [15:0] ml;
    logic [15:0] cur;
    logic [15:0] hlen;
    logic [15:0] off;
    logic [15:0] stop;
    logic        go;

    phase_d     = phase_q;
    hdr_idx_d   = hdr_idx_q;
    cur_type_d  = cur_type_q;
    hdr_next_d  = hdr_next_q;
    len_hi_d    = len_hi_q;
    remain_d    = remain_q;
    body_left_d = body_left_q;
    byte_pos_d  = byte_pos_q;
    res0        = '0;
    res1        = '0;
    n_res       = 2'd0;
    go          = 1'b1;
    ml          = (s1_len_q > MaxLen) ? MaxLen : s1_len_q;
    cur         = '0;
    hlen        = '0;
    off         = '0;
    stop        = '0;

    // a first byte restarts the walk, abandoning any message in flight
    if (s1_first_q) begin
      cur_type_d  = s1_start_q;
      remain_d    = ml;
      byte_pos_d  = '0;
      hdr_idx_d   = '0;
      hdr_next_d  = '0;
      len_hi_d    = '0;
      body_left_d = '0;
      phase_d     = PhIdle;
      if (ml == '0 || s1_start_q == IsakmpNptypeNone) begin
        res0  = '{kind: KindDone, ptype: '0, pnext: '0, offset: '0, length: '0,
                  last: 1'b1};
        n_res = 2'd1;
        go    = 1'b0;
      end else if (ml <= HdrBytes) begin
        res0  = '{kind: KindShort, ptype: s1_start_q, pnext: '0, offset: '0,
                  length: '0, last: 1'b1};
        n_res = 2'd1;
        go    = 1'b0;
      end else begin
        phase_d = PhHeader;
      end
    end

    if (go && phase_d != PhIdle) begin
      cur        = byte_pos_d;
      byte_pos_d = cur + 16'd1;
      if (phase_d == PhBody) begin
        // skipping the payload body
        body_left_d = body_left_d - 16'd1;
        if (body_left_d == '0) begin
          phase_d   = PhHeader;
          hdr_idx_d = '0;
        end
      end else begin
        case (hdr_idx_d)
          2'd0: begin
            hdr_next_d = s1_byte_q;
            hdr_idx_d  = 2'd1;
          end
          2'd1: begin
            hdr_idx_d = 2'd2;
          end
          2'd2: begin
            len_hi_d  = s1_byte_q;
            hdr_idx_d = 2'd3;
          end
          default: begin
            // last header byte: the whole header is known
            hdr_idx_d = 2'd0;
            hlen      = {len_hi_d, s1_byte_q};
            off       = cur - 16'd3;
            if (hlen < HdrBytes || hlen > remain_d) begin
              phase_d = PhIdle;
              res0    = '{kind: KindBadLen, ptype: cur_type_d, pnext: hdr_next_d,
                          offset: off, length: hlen, last: 1'b1};
              n_res   = 2'd1;
            end else begin
              res0       = '{kind: KindPayload, ptype: cur_type_d, pnext: hdr_next_d,
                             offset: off, length: hlen, last: 1'b1};
              n_res      = 2'd1;
              remain_d   = remain_d - hlen;
              cur_type_d = hdr_next_d;
              stop       = off + hlen;
              if (remain_d == '0 || hdr_next_d == IsakmpNptypeNone) begin
                phase_d   = PhIdle;
                res0.last = 1'b0;
                res1      = '{kind: KindDone, ptype: '0, pnext: '0, offset: stop,
                              length: '0, last: 1'b1};
                n_res     = 2'd2;
              end else if (remain_d <= HdrBytes) begin
                phase_d   = PhIdle;
                res0.last = 1'b0;
                res1      = '{kind: KindShort, ptype: hdr_next_d, pnext: '0,
                              offset: stop, length: '0, last: 1'b1};
                n_res     = 2'd2;
              end else if (hlen == HdrBytes) begin
                phase_d = PhHeader;
              end else begin
                body_left_d = hlen - HdrBytes;
                phase_d     = PhBody;
              end
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      hdr_idx_q   <= '0;
      cur_type_q  <= '0;
      hdr_next_q  <= '0;
      len_hi_q    <= '0;
      remain_q    <= '0;
      body_left_q <= '0;
      byte_pos_q  <= '0;
    end else if (s1_fire) begin
      phase_q     <= phase_d;
      hdr_idx_q   <= hdr_idx_d;
      cur_type_q  <= cur_type_d;
      hdr_next_q  <= hdr_next_d;
      len_hi_q    <= len_hi_d;
      remain_q    <= remain_d;
      body_left_q <= body_left_d;
      byte_pos_q  <= byte_pos_d;
    end
  end

  // result queue pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (s1_fire) begin
        wr_ptr_q <= wr_ptr_q + n_res;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 2'd1;
      end
      count_q <= count_q + (s1_fire ? {1'b0, n_res} : 3'd0) - {2'b00, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && n_res != 2'd0) begin
      queue_q[wr_ptr_q] <= res0;
    end
    if (s1_fire && n_res == 2'd2) begin
      queue_q[wr_ptr_q + 2'd1] <= res1;
    end
  end

  assign out_valid_o      = (count_q != 3'd0);
  assign record_kind_o    = queue_q[rd_ptr_q].kind;
  assign payload_type_o   = queue_q[rd_ptr_q].ptype;
  assign payload_next_o   = queue_q[rd_ptr_q].pnext;
  assign payload_offset_o = queue_q[rd_ptr_q].offset;
  assign payload_length_o = queue_q[rd_ptr_q].length;
  assign run_last_o       = queue_q[rd_ptr_q].last;

endmodule

>>> sim/isakmp_payload_chain_parser_tb.sv
`timescale 1ns / 100ps

module isakmp_payload_chain_parser_tb;
  import ipcp_pkg::*;

  // where the walk stands between bytes
  typedef enum logic [1:0] {
    PhaseIdle,
    PhaseHeader,
    PhaseBody
  } walk_phase_e;

  // shadow of the chain walk plus the records still owed by the block
  class chain_scoreboard;
    walk_phase_e phase;
    logic [1:0]  hdr_idx;
    logic [7:0]  cur_type;
    logic [7:0]  next_type;
    logic [7:0]  len_hi;
    logic [15:0] remaining;
    logic [15:0] body_left;
    logic [15:0] position;
    result_t     expected_records[$];
    int unsigned fails;

    function new();
      phase     = PhaseIdle;
      hdr_idx   = '0;
      cur_type  = '0;
      next_type = '0;
      len_hi    = '0;
      remaining = '0;
      body_left = '0;
      position  = '0;
      fails     = 0;
    endfunction

    function int unsigned pending();
      return expected_records.size();
    endfunction

    function void add_record(rec_kind_e kind, logic [7:0] ty, logic [7:0] nx,
                             logic [15:0] off, logic [15:0] len, logic last);
      result_t rec;
      rec.kind   = kind;
      rec.ptype  = ty;
      rec.pnext  = nx;
      rec.offset = off;
      rec.length = len;
      rec.last   = last;
      expected_records.push_back(rec);
    endfunction

    // walks one accepted byte, returns 1 when the byte was part of a message
    function bit note_byte(logic [7:0] b, logic first, logic [7:0] st, logic [15:0] ml);
      logic [15:0] cur;
      logic [15:0] hlen;
      logic [15:0] off;
      logic [15:0] left;
      logic [7:0]  nxt;
      if (first) begin
        if (ml > MaxMessageBytesDef) ml = 16'(MaxMessageBytesDef);
        cur_type  = st;
        remaining = ml;
        position  = '0;
        hdr_idx   = '0;
        next_type = '0;
        len_hi    = '0;
        body_left = '0;
        phase     = PhaseIdle;
        if (ml == 16'd0 || st == IsakmpNptypeNone) begin
          add_record(KindDone, 8'd0, 8'd0, 16'd0, 16'd0, 1'b1);
          return 1'b1;
        end
        if (ml <= HdrBytes) begin
          add_record(KindShort, st, 8'd0, 16'd0, 16'd0, 1'b1);
          return 1'b1;
        end
        phase = PhaseHeader;
      end
      if (phase == PhaseIdle) return 1'b0;
      cur      = position;
      position = cur + 16'd1;
      if (phase == PhaseBody) begin
        body_left = body_left - 16'd1;
        if (body_left == 16'd0) begin
          phase   = PhaseHeader;
          hdr_idx = '0;
        end
        return 1'b1;
      end
      case (hdr_idx)
        2'd0: begin
          next_type = b;
          hdr_idx   = 2'd1;
          return 1'b1;
        end
        2'd1: begin
          hdr_idx = 2'd2;
          return 1'b1;
        end
        2'd2: begin
          len_hi  = b;
          hdr_idx = 2'd3;
          return 1'b1;
        end
        default: ;
      endcase
      // last header byte: the whole verdict is known here
      hdr_idx = '0;
      hlen    = {len_hi, b};
      off     = cur - 16'd3;
      nxt     = next_type;
      if (hlen < HdrBytes || hlen > remaining) begin
        phase = PhaseIdle;
        add_record(KindBadLen, cur_type, nxt, off, hlen, 1'b1);
        return 1'b1;
      end
      left = remaining - hlen;
      if (left == 16'd0 || nxt == IsakmpNptypeNone) begin
        add_record(KindPayload, cur_type, nxt, off, hlen, 1'b0);
        add_record(KindDone, 8'd0, 8'd0, off + hlen, 16'd0, 1'b1);
        phase = PhaseIdle;
      end else if (left <= HdrBytes) begin
        add_record(KindPayload, cur_type, nxt, off, hlen, 1'b0);
        add_record(KindShort, nxt, 8'd0, off + hlen, 16'd0, 1'b1);
        phase = PhaseIdle;
      end else begin
        add_record(KindPayload, cur_type, nxt, off, hlen, 1'b1);
        if (hlen == HdrBytes) begin
          phase = PhaseHeader;
        end else begin
          body_left = hlen - HdrBytes;
          phase     = PhaseBody;
        end
      end
      remaining = left;
      cur_type  = nxt;
      return 1'b1;
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s expected %0d actual %0d", name, want, got);
        fails++;
      end
    endfunction

    function void check_record(result_t got);
      result_t want;
      if (expected_records.size() == 0) begin
        $error("record_kind expected none actual %0d", got.kind);
        fails++;
        return;
      end
      want = expected_records.pop_front();
      compare_field("record_kind", want.kind, got.kind);
      compare_field("payload_type", want.ptype, got.ptype);
      compare_field("payload_next", want.pnext, got.pnext);
      compare_field("payload_offset", want.offset, got.offset);
      compare_field("payload_length", want.length, got.length);
      compare_field("run_last", want.last, got.last);
    endfunction
  endclass

  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        in_valid_i       = 1'b0;
  logic        in_ready_o;
  logic [7:0]  byte_value_i     = '0;
  logic        first_byte_i     = 1'b0;
  logic [7:0]  start_type_i     = '0;
  logic [15:0] message_length_i = '0;
  logic        out_valid_o;
  logic        out_ready_i      = 1'b0;
  logic [1:0]  record_kind_o;
  logic [7:0]  payload_type_o;
  logic [7:0]  payload_next_o;
  logic [15:0] payload_offset_o;
  logic [15:0] payload_length_o;
  logic        run_last_o;

  chain_scoreboard chain_check;
  bit              idle_on    = 1'b1;
  int unsigned     bytes_used = 0;
  int unsigned     stall_left = 0;
  logic [7:0]      msg_q[$];
  int unsigned     hdr_pos[$];

  isakmp_payload_chain_parser dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .byte_value_i,
    .first_byte_i,
    .start_type_i,
    .message_length_i,
    .out_valid_o,
    .out_ready_i,
    .record_kind_o,
    .payload_type_o,
    .payload_next_o,
    .payload_offset_o,
    .payload_length_o,
    .run_last_o
  );

  always #2 clk_i = ~clk_i;

  // output side: stalls come in random bursts while idle_on is set
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left = stall_left - 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        stall_left = $urandom_range(0, 4);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // every record taken by the output side is checked against the oldest one owed
  always @(posedge clk_i) begin : record_monitor
    result_t seen;
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen.kind   = rec_kind_e'(record_kind_o);
      seen.ptype  = payload_type_o;
      seen.pnext  = payload_next_o;
      seen.offset = payload_offset_o;
      seen.length = payload_length_o;
      seen.last   = run_last_o;
      chain_check.check_record(seen);
    end
  end

  // one request: optional idle burst, then hold valid until it is taken
  task automatic send_byte(logic [7:0] b, logic first, logic [7:0] st, logic [15:0] ml);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    byte_value_i     <= b;
    first_byte_i     <= first;
    start_type_i     <= st;
    message_length_i <= ml;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    void'(chain_check.note_byte(b, first, st, ml));
    bytes_used++;
  endtask

  // sends the bytes in msg_q, the first one opening a message
  task automatic send_msg(logic [7:0] st, logic [15:0] ml);
    foreach (msg_q[i]) begin
      if (i == 0) send_byte(msg_q[i], 1'b1, st, ml);
      else send_byte(msg_q[i], 1'b0, 8'($urandom), 16'($urandom));
    end
  endtask

  // sender holds off until every owed record has come out
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (chain_check.pending() != 0) @(posedge clk_i);
  endtask

  // well-formed chain of generic payloads with random content
  task automatic build_chain(int unsigned count, bit end_none);
    int unsigned len;
    logic [7:0]  nxt;
    msg_q.delete();
    hdr_pos.delete();
    for (int unsigned i = 0; i < count; i++) begin
      len = ($urandom_range(0, 3) == 0) ? 4 : $urandom_range(5, 24);
      nxt = (end_none && i == count - 1) ? IsakmpNptypeNone : 8'($urandom_range(1, 255));
      hdr_pos.push_back(msg_q.size());
      msg_q.push_back(nxt);
      msg_q.push_back(8'($urandom));
      msg_q.push_back(8'(len >> 8));
      msg_q.push_back(8'(len));
      repeat (len - 4) msg_q.push_back(8'($urandom));
    end
  endtask

  // pads the message with bytes past its declared end
  task automatic add_trailing(int unsigned count);
    repeat (count) msg_q.push_back(8'($urandom));
  endtask

  initial begin
    #2_000_000;
    $display("isakmp_payload_chain_parser: mismatch");
    $finish;
  end

  initial begin
    int unsigned total;
    int unsigned k;
    int unsigned left;
    int unsigned len;
    chain_check = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // stray byte straight after reset
    send_byte(8'hA5, 1'b0, 8'hFF, 16'hFFFF);
    // empty start: no first type, then zero length
    msg_q = '{8'h00};
    send_msg(8'h00, 16'd100);
    msg_q = '{8'h11};
    send_msg(8'h22, 16'd0);
    // short start
    msg_q = '{8'h33};
    send_msg(8'hFF, 16'd4);
    // bare header leaving four bytes, then too few bytes
    msg_q = '{8'hFF, 8'h00, 8'h00, 8'h04};
    send_msg(8'h01, 16'd8);
    // header closing the chain, one trailing byte ignored
    msg_q = '{8'h00, 8'hFF, 8'h00, 8'h05, 8'hFF};
    send_msg(8'h80, 16'd5);
    // length below the header size
    msg_q = '{8'h01, 8'h00, 8'h00, 8'h03};
    send_msg(8'h02, 16'd8);
    // largest message and length: no bytes remain, a trailing byte is ignored
    msg_q = '{8'h80, 8'h00, 8'hFF, 8'hFF, 8'h5A};
    send_msg(8'h7F, 16'hFFFF);
    // length beyond what remains
    msg_q = '{8'h80, 8'h00, 8'hFF, 8'hFF};
    send_msg(8'h7F, 16'd6);
    drain();

    while (bytes_used < 700) begin
      if (bytes_used >= 600) idle_on = 1'b0;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          // chain ends on a none type, sometimes with spare bytes behind it
          build_chain($urandom_range(1, 4), 1'b1);
          total = msg_q.size();
          if ($urandom_range(0, 3) == 0) add_trailing($urandom_range(1, 6));
          send_msg(8'($urandom_range(1, 255)), 16'(msg_q.size() - (msg_q.size() - total)
                                                  + (msg_q.size() - total)));
        end
        5: begin
          // bytes run out exactly, or leave too few for another header
          build_chain($urandom_range(1, 4), 1'b0);
          total = msg_q.size() + (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 4));
          add_trailing(total - msg_q.size() + $urandom_range(0, 2));
          send_msg(8'($urandom_range(1, 255)), 16'(total));
        end
        6: begin
          // one header carries a bad length
          build_chain($urandom_range(1, 4), 1'b1);
          total = msg_q.size();
          k     = hdr_pos[$urandom_range(0, hdr_pos.size() - 1)];
          left  = total - k;
          len   = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3)
                                              : $urandom_range(left + 1, 65535);
          msg_q[k + 2] = 8'(len >> 8);
          msg_q[k + 3] = 8'(len);
          send_msg(8'($urandom_range(1, 255)), 16'(total));
        end
        7: begin
          // random bytes under a random message length, cut off by what follows
          msg_q.delete();
          add_trailing($urandom_range(1, 40));
          send_msg(8'($urandom), 16'($urandom_range(1, 65535)));
        end
        8: begin
          // well-formed chain abandoned part way by a restart
          build_chain($urandom_range(1, 4), 1'b1);
          total = msg_q.size();
          msg_q = msg_q[0 : $urandom_range(0, total - 1)];
          send_msg(8'($urandom_range(1, 255)), 16'(total));
        end
        default: begin
          // loose bytes without a message start
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0, 8'($urandom),
                                                   16'($urandom));
        end
      endcase
      if ($urandom_range(0, 29) == 0) drain();
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (chain_check.fails == 0 && chain_check.pending() == 0) begin
      $display("isakmp_payload_chain_parser: match");
    end else begin
      $display("isakmp_payload_chain_parser: mismatch");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/ipcp_pkg.sv
rtl/isakmp_payload_chain_parser.sv
sim/isakmp_payload_chain_parser_tb.sv
